// File: rtl/sxb_pkg.sv
// Package: widths, word types, register indexes and defaults of the seam cross-fade blend.
package sxb_pkg;

	localparam int PIX_W     = 8;
	localparam int CFG_W     = 12;
	localparam int COL_W     = 11;
	localparam int CH_N      = 3;
	localparam int QUO_BITS  = PIX_W;
	localparam int NUM_W     = PIX_W + CFG_W;
	localparam int CFG_IDX_W = 1;

	localparam int MAX_HALF_WIDTH_DEF = 2048;

	localparam logic [CFG_W-1:0] HALF_WIDTH_RST = CFG_W'(1024);
	localparam logic [CFG_W-1:0] SEAM_WIDTH_RST = CFG_W'(64);

	localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEAM_WIDTH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [CH_N-1:0]  rgb_t;
	typedef logic [NUM_W-1:0] num_t;
	typedef num_t [CH_N-1:0]  num3_t;

	typedef struct packed {
		logic             seam;
		rgb_t             prim;
		rgb_t             sec;
		logic [CFG_W-1:0] k;
		logic [CFG_W-1:0] sk;
		logic [CFG_W-1:0] sw;
	} front_t;

	typedef struct packed {
		logic             seam;
		rgb_t             prim;
		logic [CFG_W-1:0] sw;
		num3_t            rem;
		rgb_t             quo;
	} cell_t;

endpackage

// File: rtl/sxb_front.sv
// Front stage: clamps the configuration, finds the seam zone and the two weights.
module sxb_front #(
	parameter int MAX_HALF_WIDTH = sxb_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [sxb_pkg::COL_W-1:0] column,
	input  sxb_pkg::rgb_t            prim,
	input  sxb_pkg::rgb_t            sec,
	input  logic [sxb_pkg::CFG_W-1:0] half_width,
	input  logic [sxb_pkg::CFG_W-1:0] seam_width,
	output logic                     out_valid,
	input  logic                     out_stall,
	output sxb_pkg::front_t          out_word
);
	import sxb_pkg::*;

	localparam int CFG_MAX = (1 << CFG_W) - 1;
	localparam int HCAP    = (MAX_HALF_WIDTH > CFG_MAX) ? CFG_MAX : MAX_HALF_WIDTH;
	localparam logic [CFG_W-1:0] HALF_CAP = CFG_W'(HCAP);

	logic             valid_s1;
	front_t           word_s1;
	logic             load;
	logic [CFG_W-1:0] h;
	logic [CFG_W-1:0] s;
	logic [CFG_W-1:0] start;
	logic [CFG_W-1:0] col_x;
	front_t           word_d;

	assign in_stall  = valid_s1 && out_stall;
	assign load      = !in_stall;
	assign out_valid = valid_s1;
	assign out_word  = word_s1;

	always_comb begin
		h     = (half_width > HALF_CAP) ? HALF_CAP : half_width;
		s     = (seam_width > h) ? h : seam_width;
		start = h - s;
		col_x = {{(CFG_W-COL_W){1'b0}}, column};
		word_d.seam = (s != '0) && (col_x >= start) && (col_x < h);
		word_d.prim = prim;
		word_d.sec  = sec;
		word_d.k    = col_x - start;
		word_d.sk   = s - (col_x - start);
		word_d.sw   = s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			word_s1 <= word_d;
		end
	end

endmodule

// File: rtl/sxb_weight.sv
// Weight stage: forms the weighted sum of primary and secondary for each channel.
module sxb_weight (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  sxb_pkg::front_t in_word,
	output logic            out_valid,
	input  logic            out_stall,
	output sxb_pkg::cell_t  out_word
);
	import sxb_pkg::*;

	logic  valid_s2;
	cell_t word_s2;
	cell_t word_d;
	logic  load;

	assign in_stall  = valid_s2 && out_stall;
	assign load      = !in_stall;
	assign out_valid = valid_s2;
	assign out_word  = word_s2;

	always_comb begin
		word_d.seam = in_word.seam;
		word_d.prim = in_word.prim;
		word_d.sw   = in_word.sw;
		word_d.quo  = '0;
		for (int c = 0; c < CH_N; c++) begin
			word_d.rem[c] = ({{CFG_W{1'b0}}, in_word.prim[c]} * {{PIX_W{1'b0}}, in_word.k})
				+ ({{CFG_W{1'b0}}, in_word.sec[c]} * {{PIX_W{1'b0}}, in_word.sk});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			word_s2 <= word_d;
		end
	end

endmodule

// File: rtl/sxb_div_cell.sv
// Divider cell: settles one quotient bit of all three channels and hands the word on.
module sxb_div_cell #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sxb_pkg::cell_t in_word,
	output logic           out_valid,
	input  logic           out_stall,
	output sxb_pkg::cell_t out_word
);
	import sxb_pkg::*;

	logic  valid_q;
	cell_t word_q;
	cell_t word_d;
	num_t  div_sh;
	logic  load;

	assign in_stall  = valid_q && out_stall;
	assign load      = !in_stall;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_comb begin
		div_sh = {{PIX_W{1'b0}}, in_word.sw} << BIT;
		word_d = in_word;
		for (int c = 0; c < CH_N; c++) begin
			if (in_word.rem[c] >= div_sh) begin
				word_d.rem[c]      = in_word.rem[c] - div_sh;
				word_d.quo[c][BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load && in_valid) begin
			word_q <= word_d;
		end
	end

endmodule

// File: rtl/seam_crossfade_pixel_blend.sv
// Top level: seam cross-fade pixel blend, front and weight stages, divider cell row, output word.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid / in_stall    | column, primary_*, secondary_*
//  out     | out_valid / out_stall  | out_red, out_green, out_blue, in_seam
//  cfg     | cfg_wen                | cfg_index, cfg_data (0 half_width, 1 seam_width)
//
// One word per cycle sustained while out_stall is low; a word passes through
// front, weight, eight divider cells and the output register, one quotient bit per cell.
// Reset clears every valid bit and loads half_width 1024, seam_width 64; no clearing pass.
// A stall on the output holds only the full stages; in_stall rises once every stage is full.
module seam_crossfade_pixel_blend #(
	parameter int MAX_HALF_WIDTH = sxb_pkg::MAX_HALF_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [sxb_pkg::COL_W-1:0]     column,
	input  logic [sxb_pkg::PIX_W-1:0]     primary_red,
	input  logic [sxb_pkg::PIX_W-1:0]     primary_green,
	input  logic [sxb_pkg::PIX_W-1:0]     primary_blue,
	input  logic [sxb_pkg::PIX_W-1:0]     secondary_red,
	input  logic [sxb_pkg::PIX_W-1:0]     secondary_green,
	input  logic [sxb_pkg::PIX_W-1:0]     secondary_blue,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [sxb_pkg::PIX_W-1:0]     out_red,
	output logic [sxb_pkg::PIX_W-1:0]     out_green,
	output logic [sxb_pkg::PIX_W-1:0]     out_blue,
	output logic                         in_seam,
	input  logic                         cfg_wen,
	input  logic [sxb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sxb_pkg::CFG_W-1:0]     cfg_data
);
	import sxb_pkg::*;

	logic [CFG_W-1:0] half_width_q;
	logic [CFG_W-1:0] seam_width_q;

	rgb_t   prim;
	rgb_t   sec;
	logic   front_valid;
	logic   front_stall;
	front_t front_word;

	logic                valid_c [QUO_BITS+1];
	logic                stall_c [QUO_BITS+1];
	cell_t               word_c  [QUO_BITS+1];

	logic   out_valid_q;
	rgb_t   out_rgb_q;
	logic   out_seam_q;
	logic   out_load;
	cell_t  last_word;
	logic   last_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q <= HALF_WIDTH_RST;
			seam_width_q <= SEAM_WIDTH_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_HALF_WIDTH: half_width_q <= cfg_data;
				REG_SEAM_WIDTH: seam_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign prim[0] = primary_red;
	assign prim[1] = primary_green;
	assign prim[2] = primary_blue;
	assign sec[0]  = secondary_red;
	assign sec[1]  = secondary_green;
	assign sec[2]  = secondary_blue;

	sxb_front #(
		.MAX_HALF_WIDTH(MAX_HALF_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.column    (column),
		.prim      (prim),
		.sec       (sec),
		.half_width(half_width_q),
		.seam_width(seam_width_q),
		.out_valid (front_valid),
		.out_stall (front_stall),
		.out_word  (front_word)
	);

	sxb_weight u_weight (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (front_valid),
		.in_stall (front_stall),
		.in_word  (front_word),
		.out_valid(valid_c[0]),
		.out_stall(stall_c[0]),
		.out_word (word_c[0])
	);

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_cell
		sxb_div_cell #(
			.BIT(QUO_BITS - 1 - i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (valid_c[i]),
			.in_stall (stall_c[i]),
			.in_word  (word_c[i]),
			.out_valid(valid_c[i+1]),
			.out_stall(stall_c[i+1]),
			.out_word (word_c[i+1])
		);
	end

	assign last_word           = word_c[QUO_BITS];
	assign last_valid          = valid_c[QUO_BITS];
	assign stall_c[QUO_BITS]   = out_valid_q && out_stall;
	assign out_load            = !stall_c[QUO_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= last_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && last_valid) begin
			out_rgb_q  <= last_word.seam ? last_word.quo : last_word.prim;
			out_seam_q <= last_word.seam;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_rgb_q[0];
	assign out_green = out_rgb_q[1];
	assign out_blue  = out_rgb_q[2];
	assign in_seam   = out_seam_q;

	a_accept_fills_front: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> front_valid)
		else $error("accepted word did not reach the front stage");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && last_valid && front_valid))
		else $error("input stalled while the pipeline had room");

	a_last_cell_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(last_valid && out_valid && out_stall) |=> last_valid)
		else $error("last divider cell dropped a word under output stall");

	a_remainder_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(last_valid && last_word.seam) |->
			((last_word.rem[0] < {{PIX_W{1'b0}}, last_word.sw})
			&& (last_word.rem[1] < {{PIX_W{1'b0}}, last_word.sw})
			&& (last_word.rem[2] < {{PIX_W{1'b0}}, last_word.sw})))
		else $error("divider remainder not below seam width");

endmodule
